### rtl/core/utfje_pkg.sv
// ----------------------------------------------------------------------------
// utfje_pkg
// Shared types, character codes and helpers of the JSON string escaper.
// ----------------------------------------------------------------------------
package utfje_pkg;

   // Token kinds passed from the front sequencer to the emitter.
   typedef enum logic [1:0] {
      TK_LIT = 2'd0,   // one character
      TK_ESC = 2'd1,   // backslash, then one character
      TK_UNI = 2'd2    // \uXXXX from a 16-bit unit
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [15:0]  data;
      logic         closes;
      logic         last;
   } tok_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_LOW_U  = 7'h75;
   localparam logic [6:0] CH_LOW_N  = 7'h6E;
   localparam logic [6:0] CH_LOW_R  = 7'h72;
   localparam logic [6:0] CH_LOW_T  = 7'h74;
   localparam logic [6:0] CH_LOW_B  = 7'h62;
   localparam logic [6:0] CH_LOW_F  = 7'h66;

   localparam logic [2:0] STEP_LIT_LAST = 3'd0;
   localparam logic [2:0] STEP_ESC_LAST = 3'd1;
   localparam logic [2:0] STEP_UNI_LAST = 3'd5;

   function automatic logic [6:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return 7'h30 + {3'b000, n};
      end else begin
         return 7'h57 + {3'b000, n};
      end
   endfunction

   function automatic logic [2:0] last_step(input tok_kind_type k);
      case (k)
         TK_LIT:  return STEP_LIT_LAST;
         TK_ESC:  return STEP_ESC_LAST;
         TK_UNI:  return STEP_UNI_LAST;
         default: return STEP_LIT_LAST;
      endcase
   endfunction

endpackage

### rtl/core/utfje_front.sv
// ----------------------------------------------------------------------------
// utfje_front
// Accepts input bytes, tracks UTF-8 decode state and issues output tokens.
// ----------------------------------------------------------------------------
module utfje_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_has_byte,
   input  logic                   req_end_of_string,
   input  utfje_pkg::q_status_type q_status,
   output utfje_pkg::push_type    push
);
   import utfje_pkg::*;

   typedef enum logic [7:0] {
      PH_IDLE  = 8'b0000_0001,
      PH_OPEN  = 8'b0000_0010,
      PH_FLUSH = 8'b0000_0100,
      PH_BYTE  = 8'b0000_1000,
      PH_LOW   = 8'b0001_0000,
      PH_ENDFL = 8'b0010_0000,
      PH_CLOSE = 8'b0100_0000,
      PH_DONE  = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic        inside_ff, inside_in;
   logic [7:0]  pend_ff [3];
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [1:0]  need_ff, need_in;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  fidx_ff, fidx_in;
   logic [15:0] lo_ff, lo_in;
   logic [7:0]  byte_ff, byte_in;
   logic        has_ff, has_in;
   logic        end_ff, end_in;
   tok_type     hold_ff, hold_in;
   logic        hold_vld_ff, hold_vld_in;

   logic        pw_en;
   logic [1:0]  pw_idx;
   logic [7:0]  pend_rd;
   logic        prod, done_push, push_need, go, accept;
   tok_type     tok_new;
   logic [20:0] new_acc, adj;

   function automatic tok_type mk_tok(input tok_kind_type k, input logic [15:0] d,
                                      input logic cl);
      tok_type t;
      t.kind   = k;
      t.data   = d;
      t.closes = cl;
      t.last   = 1'b0;
      return t;
   endfunction

   // Where an item goes once the opening quote is handled.
   function automatic phase_type after_open(input logic has, input logic [7:0] b,
                                            input logic [1:0] pcnt);
      if (!has) begin
         return PH_ENDFL;
      end else if (pcnt != 2'd0 && b[7:6] != 2'b10) begin
         return PH_FLUSH;
      end else begin
         return PH_BYTE;
      end
   endfunction

   always_comb begin
      case (fidx_ff)
         2'd0:    pend_rd = pend_ff[0];
         2'd1:    pend_rd = pend_ff[1];
         default: pend_rd = pend_ff[2];
      endcase
   end

   assign new_acc = {acc_ff[14:0], byte_ff[5:0]};
   assign adj     = new_acc - 21'h10000;

   assign req_stall = !(phase_ff == PH_IDLE ||
                        (phase_ff == PH_DONE && !(hold_vld_ff && q_status.full)));

   always_comb begin
      phase_in    = phase_ff;
      inside_in   = inside_ff;
      pcnt_in     = pcnt_ff;
      need_in     = need_ff;
      acc_in      = acc_ff;
      fidx_in     = fidx_ff;
      lo_in       = lo_ff;
      byte_in     = byte_ff;
      has_in      = has_ff;
      end_in      = end_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      pw_en       = 1'b0;
      pw_idx      = 2'd0;
      prod        = 1'b0;
      done_push   = 1'b0;
      tok_new     = mk_tok(TK_LIT, 16'h0000, 1'b0);

      case (phase_ff)
         PH_IDLE: begin
         end
         PH_OPEN: begin
            if (!inside_ff) begin
               prod    = 1'b1;
               tok_new = mk_tok(TK_LIT, {9'd0, CH_QUOTE}, 1'b0);
            end
            inside_in = 1'b1;
            fidx_in   = 2'd0;
            phase_in  = after_open(has_ff, byte_ff, pcnt_ff);
         end
         PH_FLUSH, PH_ENDFL: begin
            if (pcnt_ff == 2'd0) begin
               // only reachable at end of string with nothing pending
               need_in  = 2'd0;
               acc_in   = '0;
               phase_in = PH_CLOSE;
            end else begin
               prod    = 1'b1;
               tok_new = mk_tok(TK_UNI, {8'h00, pend_rd}, 1'b0);
               if (fidx_ff + 2'd1 == pcnt_ff) begin
                  pcnt_in  = 2'd0;
                  need_in  = 2'd0;
                  acc_in   = '0;
                  fidx_in  = 2'd0;
                  phase_in = (phase_ff == PH_FLUSH) ? PH_BYTE : PH_CLOSE;
               end else begin
                  fidx_in = fidx_ff + 2'd1;
               end
            end
         end
         PH_BYTE: begin
            phase_in = end_ff ? PH_ENDFL : PH_DONE;
            fidx_in  = 2'd0;
            if (pcnt_ff != 2'd0) begin
               // continuation byte of a pending sequence
               if (need_ff <= 2'd1) begin
                  pcnt_in = 2'd0;
                  need_in = 2'd0;
                  acc_in  = '0;
                  prod    = 1'b1;
                  if (|new_acc[20:16]) begin
                     tok_new  = mk_tok(TK_UNI, 16'hD800 + {5'd0, adj[20:10]}, 1'b0);
                     lo_in    = {6'b110111, adj[9:0]};
                     phase_in = PH_LOW;
                  end else begin
                     tok_new = mk_tok(TK_UNI, new_acc[15:0], 1'b0);
                  end
               end else begin
                  if (pcnt_ff < 2'd3) begin
                     pw_en   = 1'b1;
                     pw_idx  = pcnt_ff;
                     pcnt_in = pcnt_ff + 2'd1;
                  end
                  need_in = need_ff - 2'd1;
                  acc_in  = new_acc;
               end
            end else begin
               prod = 1'b1;
               case (byte_ff)
                  8'h22: tok_new = mk_tok(TK_ESC, {9'd0, CH_QUOTE}, 1'b0);
                  8'h5C: tok_new = mk_tok(TK_ESC, {9'd0, CH_BSLASH}, 1'b0);
                  8'h0A: tok_new = mk_tok(TK_ESC, {9'd0, CH_LOW_N}, 1'b0);
                  8'h0D: tok_new = mk_tok(TK_ESC, {9'd0, CH_LOW_R}, 1'b0);
                  8'h09: tok_new = mk_tok(TK_ESC, {9'd0, CH_LOW_T}, 1'b0);
                  8'h08: tok_new = mk_tok(TK_ESC, {9'd0, CH_LOW_B}, 1'b0);
                  8'h0C: tok_new = mk_tok(TK_ESC, {9'd0, CH_LOW_F}, 1'b0);
                  default: begin
                     if (byte_ff < 8'h20) begin
                        tok_new = mk_tok(TK_UNI, {8'h00, byte_ff}, 1'b0);
                     end else if (byte_ff < 8'h80) begin
                        tok_new = mk_tok(TK_LIT, {8'h00, byte_ff}, 1'b0);
                     end else if (byte_ff[7:5] == 3'b110 || byte_ff[7:4] == 4'b1110 ||
                                  byte_ff[7:3] == 5'b11110) begin
                        // lead byte: buffer it, nothing to emit yet
                        prod    = 1'b0;
                        pw_en   = 1'b1;
                        pw_idx  = 2'd0;
                        pcnt_in = 2'd1;
                        if (byte_ff[7:5] == 3'b110) begin
                           need_in = 2'd1;
                           acc_in  = {16'd0, byte_ff[4:0]};
                        end else if (byte_ff[7:4] == 4'b1110) begin
                           need_in = 2'd2;
                           acc_in  = {17'd0, byte_ff[3:0]};
                        end else begin
                           need_in = 2'd3;
                           acc_in  = {18'd0, byte_ff[2:0]};
                        end
                     end else begin
                        tok_new = mk_tok(TK_UNI, {8'h00, byte_ff}, 1'b0);
                     end
                  end
               endcase
            end
         end
         PH_LOW: begin
            prod     = 1'b1;
            tok_new  = mk_tok(TK_UNI, lo_ff, 1'b0);
            fidx_in  = 2'd0;
            phase_in = end_ff ? PH_ENDFL : PH_DONE;
         end
         PH_CLOSE: begin
            prod      = 1'b1;
            tok_new   = mk_tok(TK_LIT, {9'd0, CH_QUOTE}, 1'b1);
            inside_in = 1'b0;
            phase_in  = PH_DONE;
         end
         PH_DONE: begin
            done_push   = 1'b1;
            hold_vld_in = 1'b0;
            phase_in    = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      // One token is held back so the last one of an item can be flagged.
      push_need = hold_vld_ff && (prod || done_push);
      go        = !(push_need && q_status.full);
      if (prod) begin
         hold_in     = tok_new;
         hold_vld_in = 1'b1;
      end

      accept = req_valid && !req_stall;
      if (accept) begin
         byte_in = req_data_byte;
         has_in  = req_has_byte;
         end_in  = req_end_of_string;
         fidx_in = 2'd0;
         if (!req_has_byte && !req_end_of_string) begin
            phase_in = PH_IDLE;
         end else if (!inside_in) begin
            phase_in = PH_OPEN;
         end else begin
            phase_in = after_open(req_has_byte, req_data_byte, pcnt_ff);
         end
      end

      if (!go) begin
         phase_in    = phase_ff;
         inside_in   = inside_ff;
         pcnt_in     = pcnt_ff;
         need_in     = need_ff;
         acc_in      = acc_ff;
         fidx_in     = fidx_ff;
         lo_in       = lo_ff;
         hold_in     = hold_ff;
         hold_vld_in = hold_vld_ff;
         pw_en       = 1'b0;
      end
   end

   always_comb begin
      push.valid    = push_need && go;
      push.tok      = hold_ff;
      push.tok.last = done_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         inside_ff   <= 1'b0;
         pcnt_ff     <= 2'd0;
         need_ff     <= 2'd0;
         acc_ff      <= '0;
         fidx_ff     <= 2'd0;
         hold_vld_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         inside_ff   <= inside_in;
         pcnt_ff     <= pcnt_in;
         need_ff     <= need_in;
         acc_ff      <= acc_in;
         fidx_ff     <= fidx_in;
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      byte_ff <= byte_in;
      has_ff  <= has_in;
      end_ff  <= end_in;
      hold_ff <= hold_in;
      if (pw_en) begin
         case (pw_idx)
            2'd0:    pend_ff[0] <= byte_ff;
            2'd1:    pend_ff[1] <= byte_ff;
            2'd2:    pend_ff[2] <= byte_ff;
            default: ;
         endcase
      end
   end

endmodule

### rtl/core/utfje_fifo.sv
// ----------------------------------------------------------------------------
// utfje_fifo
// Short token queue between the front sequencer and the emitter.
// ----------------------------------------------------------------------------
module utfje_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  utfje_pkg::push_type     push,
   input  logic                    pop,
   output utfje_pkg::tok_type      head,
   output utfje_pkg::q_status_type q_status
);
   import utfje_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   tok_type       mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          wr, rd;

   assign q_status.full  = (cnt_ff == CW'(DEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign wr   = push.valid && !q_status.full;
   assign rd   = pop && !q_status.empty;
   assign head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr && !rd) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[wr_ptr_ff] <= push.tok;
      end
   end

endmodule

### rtl/core/utfje_back.sv
// ----------------------------------------------------------------------------
// utfje_back
// Expands queued tokens into ASCII characters, one per cycle while rsp_stall
// is low, into the output register.
// ----------------------------------------------------------------------------
module utfje_back (
   input  logic                    clock,
   input  logic                    reset,
   input  utfje_pkg::tok_type      head,
   input  utfje_pkg::q_status_type q_status,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [6:0]              rsp_out_char,
   output logic                    rsp_closes_string,
   output logic                    rsp_last_of_run
);
   import utfje_pkg::*;

   tok_type    cur_ff, cur_in;
   logic       cur_vld_ff, cur_vld_in;
   logic [2:0] step_ff, step_in;
   logic       out_vld_ff, out_vld_in;
   logic [6:0] char_ff, char_in;
   logic       closes_ff, closes_in;
   logic       last_ff, last_in;

   logic       out_free, fin;
   logic [6:0] ch;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign fin      = (step_ff == last_step(cur_ff.kind));

   always_comb begin
      ch = cur_ff.data[6:0];
      case (cur_ff.kind)
         TK_LIT: ch = cur_ff.data[6:0];
         TK_ESC: ch = (step_ff == 3'd0) ? CH_BSLASH : cur_ff.data[6:0];
         TK_UNI: begin
            case (step_ff)
               3'd0:    ch = CH_BSLASH;
               3'd1:    ch = CH_LOW_U;
               3'd2:    ch = hex_char(cur_ff.data[15:12]);
               3'd3:    ch = hex_char(cur_ff.data[11:8]);
               3'd4:    ch = hex_char(cur_ff.data[7:4]);
               default: ch = hex_char(cur_ff.data[3:0]);
            endcase
         end
         default: ch = cur_ff.data[6:0];
      endcase
   end

   always_comb begin
      cur_in     = cur_ff;
      cur_vld_in = cur_vld_ff;
      step_in    = step_ff;
      out_vld_in = out_vld_ff;
      char_in    = char_ff;
      closes_in  = closes_ff;
      last_in    = last_ff;

      if (out_free) begin
         out_vld_in = cur_vld_ff;
         if (cur_vld_ff) begin
            char_in   = ch;
            closes_in = fin && cur_ff.closes;
            last_in   = fin && cur_ff.last;
            if (fin) begin
               cur_vld_in = 1'b0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
      end

      pop = !q_status.empty && (!cur_vld_ff || (out_free && fin));
      if (pop) begin
         cur_in     = head;
         cur_vld_in = 1'b1;
         step_in    = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         step_ff    <= 3'd0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         out_vld_ff <= out_vld_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      char_ff   <= char_in;
      closes_ff <= closes_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_out_char      = char_ff;
   assign rsp_closes_string = closes_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

### rtl/core/utf8_json_string_escaper.sv
// ----------------------------------------------------------------------------
// utf8_json_string_escaper
// UTF-8 byte stream in, quoted ASCII-only JSON string out, one character per
// transaction.
// ----------------------------------------------------------------------------
//  channel | ports                                               | direction
//  req     | req_valid req_stall req_data_byte req_has_byte      | in
//          | req_end_of_string                                   |
//  rsp     | rsp_valid rsp_stall rsp_out_char rsp_closes_string  | out
//          | rsp_last_of_run                                     |
//
// The front sequencer works through the steps of an item: an optional
// opening-quote step, one step per flushed pending byte, the byte step, a
// low-surrogate step, end-of-string flush steps and a closing step, plus a
// final step in which the next item may already be accepted. A plain byte
// in a string takes only the byte and final steps. The emitter drains one
// character per cycle while rsp_stall is low, via a QUEUE_DEPTH-token queue;
// it fills when the emitter lags, and req_stall holds. Reset is synchronous.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_char,
   output logic       rsp_closes_string,
   output logic       rsp_last_of_run
);
   import utfje_pkg::*;

   push_type     push;
   tok_type      head;
   q_status_type q_status;
   logic         pop;

   utfje_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_string (req_end_of_string),
      .q_status          (q_status),
      .push              (push)
   );

   utfje_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   utfje_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_closes_string (rsp_closes_string),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

### rtl/core/utfje_checker.sv
// ----------------------------------------------------------------------------
// utfje_checker
// Port-level checks of the JSON string escaper, bound to the top level.
// ----------------------------------------------------------------------------
module utfje_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_has_byte,
   input logic       req_end_of_string,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_out_char,
   input logic       rsp_closes_string,
   input logic       rsp_last_of_run
);

   // closing quote always ends the run of its transaction
   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closes_string |-> rsp_last_of_run)
      else $error("closing quote not flagged last of run");

   a_close_is_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closes_string |-> rsp_out_char == 7'h22)
      else $error("closing character is not a quote");

   // an item that produces output leaves the input busy, with req_stall raised, once it is accepted
   a_busy_after_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_has_byte || req_end_of_string) |=> req_stall)
      else $error("input accepted again right after a producing item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char))
      else $error("stalled response changed");

endmodule

bind utf8_json_string_escaper utfje_checker u_utfje_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_has_byte      (req_has_byte),
   .req_end_of_string (req_end_of_string),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_out_char      (rsp_out_char),
   .rsp_closes_string (rsp_closes_string),
   .rsp_last_of_run   (rsp_last_of_run)
);

### dv/utf8_json_string_escaper_tb.sv
// ----------------------------------------------------------------------------
// utf8_json_string_escaper_tb
// Self-checking bench for the UTF-8 to JSON string escaper. A directed pass
// hits every escape, the multi-byte forms and the malformed-input cases.
// Random strings, mostly well-formed UTF-8 with some junk mixed in, follow
// under bursty input and random output back-pressure. One long output
// hold-off forces the block to stall its input. An in-bench predictor
// builds the expected character stream, and each output transaction is
// checked against it.
// ----------------------------------------------------------------------------
module utf8_json_string_escaper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utfje_pkg::*;

   localparam int unsigned ITEM_TARGET = 480;
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned RUN_CAP     = 26;

   typedef struct packed {
      logic [6:0] ch;
      logic       closes;
      logic       last;
   } json_char_type;

   typedef enum int {
      RX_FLOW,
      RX_LIGHT,
      RX_HEAVY,
      RX_CHOPPY
   } rx_mode_type;

   // Predicts the escaped character stream and holds what is still awaited.
   class escaped_text_scoreboard;
      bit            in_string;
      logic [7:0]    held [3];
      int unsigned   held_cnt;
      int unsigned   conts_left;
      logic [20:0]   cp_acc = '0;
      json_char_type run [$];
      json_char_type awaited_chars [$];
      int unsigned   mismatches;

      function void put_char(logic [6:0] ch, logic closes);
         json_char_type c;
         c.ch     = ch;
         c.closes = closes;
         c.last   = 1'b0;
         if (run.size() < RUN_CAP) run.insert(run.size(), c);
      endfunction

      function void put_pair(logic [6:0] ch);
         put_char(CH_BSLASH, 1'b0);
         put_char(ch, 1'b0);
      endfunction

      function logic [6:0] hex_digit(logic [3:0] n);
         return (n < 4'd10) ? 7'h30 + 7'(n) : 7'h61 + 7'(n - 4'd10);
      endfunction

      function void put_unit(logic [15:0] u);
         put_char(CH_BSLASH, 1'b0);
         put_char(CH_LOW_U, 1'b0);
         for (int i = 3; i >= 0; i--) put_char(hex_digit(u[4*i +: 4]), 1'b0);
      endfunction

      function void put_code_point(logic [20:0] cp);
         logic [20:0] adj;
         if (cp > 21'hFFFF) begin
            // code points past 0x10FFFF still split in two
            adj = cp - 21'h10000;
            put_unit(16'hD800 + 16'(adj[20:10]));
            put_unit(16'hDC00 + 16'(adj[9:0]));
         end else begin
            put_unit(cp[15:0]);
         end
      endfunction

      function void flush_held();
         for (int k = 0; k < held_cnt; k++) put_unit({8'h00, held[k]});
         held_cnt   = 0;
         conts_left = 0;
         cp_acc     = '0;
      endfunction

      function void start_seq(logic [7:0] b, logic [20:0] bits, int unsigned n);
         held[0]    = b;
         held_cnt   = 1;
         conts_left = n;
         cp_acc     = bits;
      endfunction

      function void fresh_byte(logic [7:0] b);
         case (b)
            8'h22: put_pair(CH_QUOTE);
            8'h5C: put_pair(CH_BSLASH);
            8'h0A: put_pair(CH_LOW_N);
            8'h0D: put_pair(CH_LOW_R);
            8'h09: put_pair(CH_LOW_T);
            8'h08: put_pair(CH_LOW_B);
            8'h0C: put_pair(CH_LOW_F);
            default: begin
               if (b < 8'h20) put_unit({8'h00, b});
               else if (b < 8'h80) put_char(b[6:0], 1'b0);
               else if (b[7:5] == 3'b110) start_seq(b, 21'(b[4:0]), 1);
               else if (b[7:4] == 4'b1110) start_seq(b, 21'(b[3:0]), 2);
               else if (b[7:3] == 5'b11110) start_seq(b, 21'(b[2:0]), 3);
               else put_unit({8'h00, b});
            end
         endcase
      endfunction

      function void take_byte(logic [7:0] b);
         logic [20:0] cp;
         if (held_cnt != 0) begin
            if (b[7:6] == 2'b10) begin
               cp_acc = {cp_acc[14:0], b[5:0]};
               if (conts_left <= 1) begin
                  cp         = cp_acc;
                  held_cnt   = 0;
                  conts_left = 0;
                  cp_acc     = '0;
                  put_code_point(cp);
               end else begin
                  if (held_cnt < 3) begin
                     held[held_cnt] = b;
                     held_cnt++;
                  end
                  conts_left--;
               end
               return;
            end
            // broken sequence: dump what was buffered, then treat b as new
            flush_held();
         end
         fresh_byte(b);
      endfunction

      function void take_item(logic [7:0] b, logic has, logic eos);
         run.delete();
         if (!has && !eos) return;
         if (!in_string) begin
            put_char(CH_QUOTE, 1'b0);
            in_string = 1'b1;
         end
         if (has) take_byte(b);
         if (eos) begin
            flush_held();
            put_char(CH_QUOTE, 1'b1);
            in_string = 1'b0;
         end
         if (run.size() > 0) run[run.size() - 1].last = 1'b1;
         foreach (run[i]) awaited_chars.insert(awaited_chars.size(), run[i]);
      endfunction

      function void check_char(logic [6:0] ch, logic closes, logic last);
         json_char_type want;
         if (awaited_chars.size() == 0) begin
            $display("%0t: expected nothing, got char %h closes %b last %b",
                     $time, ch, closes, last);
            mismatches++;
            return;
         end
         want = awaited_chars.pop_front();
         if (ch !== want.ch || closes !== want.closes || last !== want.last) begin
            $display("%0t: mismatch: expected char %h closes %b last %b,",
                     $time, want.ch, want.closes, want.last);
            $display("%0t:           got char %h closes %b last %b",
                     $time, ch, closes, last);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_has_byte = 1'b0;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_out_char;
   logic       rsp_closes_string;
   logic       rsp_last_of_run;

   escaped_text_scoreboard sb = new();

   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned quiet_cycles = 0;
   bit          squeeze_req = 1'b0;

   utf8_json_string_escaper dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_closes_string (rsp_closes_string),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #2 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer(input logic [7:0] b, input logic has, input logic eos);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_has_byte      <= has;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      sb.take_item(b, has, eos);
      if (has || eos) items_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic send_string();
      logic [7:0]  text [$];
      logic [7:0]  lead;
      int unsigned n_chars;
      int unsigned roll;
      int unsigned seq_len;
      int unsigned n_cont;
      bit          bare_end;
      n_chars = $urandom_range(0, 10);
      for (int i = 0; i < n_chars; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 50) begin
            text.insert(text.size(), 8'($urandom_range(8'h20, 8'h7F)));
         end else if (roll < 58) begin
            case ($urandom_range(0, 6))
               0: text.insert(text.size(), 8'h22);
               1: text.insert(text.size(), 8'h5C);
               2: text.insert(text.size(), 8'h0A);
               3: text.insert(text.size(), 8'h0D);
               4: text.insert(text.size(), 8'h09);
               5: text.insert(text.size(), 8'h08);
               default: text.insert(text.size(), 8'h0C);
            endcase
         end else if (roll < 64) begin
            text.insert(text.size(), 8'($urandom_range(0, 8'h1F)));
         end else if (roll >= 86 && roll < 92) begin
            // stray high byte: lone continuation, bad lead or a lead
            text.insert(text.size(), 8'($urandom_range(8'h80, 8'hFF)));
         end else begin
            seq_len = $urandom_range(2, 4);
            case (seq_len)
               2: lead = {3'b110, 5'($urandom)};
               3: lead = {4'b1110, 4'($urandom)};
               default: lead = {5'b11110, 3'($urandom)};
            endcase
            // from 92 up: cut short, so it breaks or gets truncated
            n_cont = (roll < 86) ? seq_len - 1 : $urandom_range(0, seq_len - 2);
            text.insert(text.size(), lead);
            repeat (n_cont) text.insert(text.size(), {2'b10, 6'($urandom)});
         end
      end
      bare_end = (text.size() == 0) || ($urandom_range(0, 3) == 0);
      foreach (text[i]) begin
         if ($urandom_range(0, 19) == 0) offer(8'($urandom), 1'b0, 1'b0);
         offer(text[i], 1'b1, (i == text.size() - 1) && !bare_end);
      end
      if (bare_end) offer(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      offer(8'hA5, 1'b0, 1'b1);        // empty string
      offer(8'h5A, 1'b0, 1'b0);        // idle transaction
      offer(8'h00, 1'b1, 1'b0);
      offer(8'h22, 1'b1, 1'b0);
      offer(8'h5C, 1'b1, 1'b0);
      offer(8'h0A, 1'b1, 1'b0);
      offer(8'h0D, 1'b1, 1'b0);
      offer(8'h09, 1'b1, 1'b0);
      offer(8'h08, 1'b1, 1'b0);
      offer(8'h0C, 1'b1, 1'b0);
      offer(8'h7F, 1'b1, 1'b0);
      offer(8'hC3, 1'b1, 1'b0);
      offer(8'hA9, 1'b1, 1'b0);
      offer(8'hE2, 1'b1, 1'b0);
      offer(8'h82, 1'b1, 1'b0);
      offer(8'hAC, 1'b1, 1'b0);
      // code point 0x110000, past the Unicode range
      offer(8'hF4, 1'b1, 1'b0);
      offer(8'h90, 1'b1, 1'b0);
      offer(8'h80, 1'b1, 1'b0);
      offer(8'h80, 1'b1, 1'b0);
      offer(8'h80, 1'b1, 1'b0);        // lone continuation
      offer(8'hFF, 1'b1, 1'b0);        // invalid lead
      offer(8'hE2, 1'b1, 1'b0);
      offer(8'h41, 1'b1, 1'b0);        // breaks the 3-byte sequence
      offer(8'hF0, 1'b1, 1'b0);
      offer(8'h9F, 1'b1, 1'b1);        // string ends mid-sequence

      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 150) squeeze_req = 1'b1;
         send_string();
      end
      req_valid <= 1'b0;

      while (sb.awaited_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited_chars.size() == 0) begin
         $display("utf8_json_string_escaper verification clean");
      end else begin
         $display("utf8_json_string_escaper verification failed");
      end
      $finish;
   end

   initial begin : receiver
      rx_mode_type mode;
      int unsigned mode_left;
      int unsigned hold_left;
      bit          hold_done;
      mode      = RX_FLOW;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req && !hold_done) begin
            // long hold-off so the token queue fills and req_stall rises
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode      = rx_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               RX_FLOW:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
               RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:  rsp_stall <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_char(rsp_out_char, rsp_closes_string, rsp_last_of_run);
      end
   end

   // watchdog: no transaction on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("utf8_json_string_escaper verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
